### rtl/core/prac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prac_pkg: shared types and constants for point rotation about a pivot
// Fixed-point formats, CORDIC constants and the payloads passed between cells.
// ----------------------------------------------------------------------------
package prac_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 32;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CS_W    = 34;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = MUL_W + DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 30;
    localparam int RES_W   = SUM_W - FRAC_W + 1;
    localparam int Z_W     = 22;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [CS_W-1:0]    cs_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [RES_W-1:0]   res_t;
    typedef logic signed [Z_W-1:0]     z_t;

    localparam z_t ANG_TWO_PI      = 22'sd411775;
    localparam z_t ANG_PI          = 22'sd205887;
    localparam z_t ANG_NEG_PI      = -22'sd205887;
    localparam z_t ANG_HALF_PI     = 22'sd102944;
    localparam z_t ANG_NEG_HALF_PI = -22'sd102944;

    localparam cs_t  GAIN_Q30  = 34'sd652032874;
    localparam sum_t ROUND_Q30 = sum_t'(1) <<< (FRAC_W - 1);

    localparam coord_t COORD_MAX = 32'sh7fffffff;
    localparam coord_t COORD_MIN = 32'sh80000000;

    localparam z_t ATAN_Q16 [ATAN_ENTRIES] = '{
        22'sd51472, 22'sd30386, 22'sd16055, 22'sd8150,
        22'sd4091,  22'sd2047,  22'sd1024,  22'sd512,
        22'sd256,   22'sd128,   22'sd64,    22'sd32,
        22'sd16,    22'sd8,     22'sd4,     22'sd2,
        22'sd1,     22'sd0,     22'sd0,     22'sd0,
        22'sd0,     22'sd0,     22'sd0,     22'sd0,
        22'sd0,     22'sd0,     22'sd0,     22'sd0,
        22'sd0,     22'sd0,     22'sd0,     22'sd0
    };

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t pivot_x;
        coord_t pivot_y;
        angle_t angle;
    } point_t;

    typedef struct packed {
        cs_t    x;
        cs_t    y;
        z_t     z;
        logic   flip;
        diff_t  dx;
        diff_t  dy;
        coord_t cx;
        coord_t cy;
    } cordic_t;

    typedef struct packed {
        coord_t rotated_x;
        coord_t rotated_y;
        logic   saturated;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/prac_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prac_in_if: input item channel
// Point, pivot and angle with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prac_in_if;
    logic             valid;
    logic             ready;
    prac_pkg::coord_t point_x;
    prac_pkg::coord_t point_y;
    prac_pkg::coord_t pivot_x;
    prac_pkg::coord_t pivot_y;
    prac_pkg::angle_t angle;

    modport source (output valid, point_x, point_y, pivot_x, pivot_y, angle, input ready);
    modport sink (input valid, point_x, point_y, pivot_x, pivot_y, angle, output ready);
endinterface
`default_nettype wire

### rtl/core/prac_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prac_out_if: result item channel
// Rotated point and saturation flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prac_out_if;
    logic             valid;
    logic             ready;
    prac_pkg::coord_t rotated_x;
    prac_pkg::coord_t rotated_y;
    logic             saturated;

    modport source (output valid, rotated_x, rotated_y, saturated, input ready);
    modport sink (input valid, rotated_x, rotated_y, saturated, output ready);
endinterface
`default_nettype wire

### rtl/core/prac_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prac_reduce: angle reduction and offset stage
// Folds the angle into [-pi/2, pi/2], forms the offsets from the pivot and
// seeds the CORDIC vector.
// ----------------------------------------------------------------------------
module prac_reduce (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire prac_pkg::point_t  up_data,
    output logic                   down_valid,
    input  wire logic              down_ready,
    output prac_pkg::cordic_t      down_data
);

    logic              valid_reg;
    prac_pkg::cordic_t data_reg;
    prac_pkg::cordic_t data_next;
    prac_pkg::z_t      a0;
    prac_pkg::z_t      a1;
    prac_pkg::z_t      a2;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        a0 = {{(prac_pkg::Z_W - prac_pkg::ANGLE_W - 4){up_data.angle[prac_pkg::ANGLE_W-1]}},
              up_data.angle, 4'b0000};
        a1 = (a0 > prac_pkg::ANG_PI) ? a0 - prac_pkg::ANG_TWO_PI : a0;
        a2 = (a1 < prac_pkg::ANG_NEG_PI) ? a1 + prac_pkg::ANG_TWO_PI : a1;

        data_next.x    = prac_pkg::GAIN_Q30;
        data_next.y    = '0;
        data_next.flip = 1'b0;
        data_next.z    = a2;
        if (a2 > prac_pkg::ANG_HALF_PI)
        begin
            data_next.z    = a2 - prac_pkg::ANG_PI;
            data_next.flip = 1'b1;
        end
        else if (a2 < prac_pkg::ANG_NEG_HALF_PI)
        begin
            data_next.z    = a2 + prac_pkg::ANG_PI;
            data_next.flip = 1'b1;
        end
        data_next.dx = prac_pkg::diff_t'(up_data.point_x) - prac_pkg::diff_t'(up_data.pivot_x);
        data_next.dy = prac_pkg::diff_t'(up_data.point_y) - prac_pkg::diff_t'(up_data.pivot_y);
        data_next.cx = up_data.pivot_x;
        data_next.cy = up_data.pivot_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    a_z_folded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.z <= prac_pkg::ANG_HALF_PI &&
                       data_reg.z >= prac_pkg::ANG_NEG_HALF_PI))
        else $error("reduced angle outside half pi");

endmodule
`default_nettype wire

### rtl/core/prac_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prac_cell: one CORDIC rotation step
// Rotates the vector by +/- atan(2^-step) and passes the item to the next cell.
// ----------------------------------------------------------------------------
module prac_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [prac_pkg::STEP_W-1:0]   step,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire prac_pkg::cordic_t             up_data,
    output logic                               down_valid,
    input  wire logic                          down_ready,
    output prac_pkg::cordic_t                  down_data
);

    logic              valid_reg;
    prac_pkg::cordic_t data_reg;
    prac_pkg::cordic_t data_next;
    prac_pkg::cs_t     xs;
    prac_pkg::cs_t     ys;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        xs        = up_data.x >>> step;
        ys        = up_data.y >>> step;
        data_next = up_data;
        if (!up_data.z[prac_pkg::Z_W-1])
        begin
            data_next.x = up_data.x - ys;
            data_next.y = up_data.y + xs;
            data_next.z = up_data.z - prac_pkg::ATAN_Q16[step];
        end
        else
        begin
            data_next.x = up_data.x + ys;
            data_next.y = up_data.y - xs;
            data_next.z = up_data.z + prac_pkg::ATAN_Q16[step];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

### rtl/core/prac_combine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prac_combine: rotation products, rounding and saturation
// Four stages: quadrant sign, products, rounded sums, pivot add and clamp.
// ----------------------------------------------------------------------------
module prac_combine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire prac_pkg::cordic_t up_data,
    output logic                   down_valid,
    input  wire logic              down_ready,
    output prac_pkg::result_t      down_data
);

    // stage a: signed cos/sin
    logic             a_valid_reg;
    prac_pkg::mul_t   a_cos_reg;
    prac_pkg::mul_t   a_sin_reg;
    prac_pkg::diff_t  a_dx_reg;
    prac_pkg::diff_t  a_dy_reg;
    prac_pkg::coord_t a_cx_reg;
    prac_pkg::coord_t a_cy_reg;
    prac_pkg::cs_t    cos_next;
    prac_pkg::cs_t    sin_next;
    // stage b: products
    logic             b_valid_reg;
    prac_pkg::prod_t  b_cdx_reg;
    prac_pkg::prod_t  b_sdy_reg;
    prac_pkg::prod_t  b_sdx_reg;
    prac_pkg::prod_t  b_cdy_reg;
    prac_pkg::coord_t b_cx_reg;
    prac_pkg::coord_t b_cy_reg;
    // stage c: rounded sums
    logic             c_valid_reg;
    prac_pkg::sum_t   c_sx_reg;
    prac_pkg::sum_t   c_sy_reg;
    prac_pkg::coord_t c_cx_reg;
    prac_pkg::coord_t c_cy_reg;
    // stage d: output register
    logic              d_valid_reg;
    prac_pkg::result_t d_data_reg;
    prac_pkg::result_t d_data_next;
    prac_pkg::res_t    tx;
    prac_pkg::res_t    ty;
    logic              clip_x;
    logic              clip_y;

    logic a_rdy;
    logic b_rdy;
    logic c_rdy;
    logic d_rdy;

    assign d_rdy      = !d_valid_reg || down_ready;
    assign c_rdy      = !c_valid_reg || d_rdy;
    assign b_rdy      = !b_valid_reg || c_rdy;
    assign a_rdy      = !a_valid_reg || b_rdy;
    assign up_ready   = a_rdy;
    assign down_valid = d_valid_reg;
    assign down_data  = d_data_reg;

    function automatic prac_pkg::coord_t clamp (input prac_pkg::res_t t, output logic clip);
        logic hi_any;
        logic hi_all;
        hi_any = |t[prac_pkg::RES_W-2:prac_pkg::COORD_W-1];
        hi_all = &t[prac_pkg::RES_W-2:prac_pkg::COORD_W-1];
        clip   = 1'b0;
        clamp  = t[prac_pkg::COORD_W-1:0];
        if (!t[prac_pkg::RES_W-1] && hi_any)
        begin
            clip  = 1'b1;
            clamp = prac_pkg::COORD_MAX;
        end
        else if (t[prac_pkg::RES_W-1] && !hi_all)
        begin
            clip  = 1'b1;
            clamp = prac_pkg::COORD_MIN;
        end
    endfunction

    always_comb
    begin
        cos_next = up_data.flip ? -up_data.x : up_data.x;
        sin_next = up_data.flip ? -up_data.y : up_data.y;
    end

    always_comb
    begin
        tx = prac_pkg::res_t'(c_sx_reg >>> prac_pkg::FRAC_W) + prac_pkg::res_t'(c_cx_reg);
        ty = prac_pkg::res_t'(c_sy_reg >>> prac_pkg::FRAC_W) + prac_pkg::res_t'(c_cy_reg);
        d_data_next.rotated_x = clamp(tx, clip_x);
        d_data_next.rotated_y = clamp(ty, clip_y);
        d_data_next.saturated = clip_x || clip_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_valid_reg <= up_valid;
            if (b_rdy)
                b_valid_reg <= a_valid_reg;
            if (c_rdy)
                c_valid_reg <= b_valid_reg;
            if (d_rdy)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && up_valid)
        begin
            a_cos_reg <= cos_next[prac_pkg::MUL_W-1:0];
            a_sin_reg <= sin_next[prac_pkg::MUL_W-1:0];
            a_dx_reg  <= up_data.dx;
            a_dy_reg  <= up_data.dy;
            a_cx_reg  <= up_data.cx;
            a_cy_reg  <= up_data.cy;
        end
        if (b_rdy && a_valid_reg)
        begin
            b_cdx_reg <= prac_pkg::prod_t'(a_cos_reg) * prac_pkg::prod_t'(a_dx_reg);
            b_sdy_reg <= prac_pkg::prod_t'(a_sin_reg) * prac_pkg::prod_t'(a_dy_reg);
            b_sdx_reg <= prac_pkg::prod_t'(a_sin_reg) * prac_pkg::prod_t'(a_dx_reg);
            b_cdy_reg <= prac_pkg::prod_t'(a_cos_reg) * prac_pkg::prod_t'(a_dy_reg);
            b_cx_reg  <= a_cx_reg;
            b_cy_reg  <= a_cy_reg;
        end
        if (c_rdy && b_valid_reg)
        begin
            c_sx_reg <= prac_pkg::sum_t'(b_cdx_reg) + prac_pkg::sum_t'(b_sdy_reg)
                        + prac_pkg::ROUND_Q30;
            c_sy_reg <= prac_pkg::sum_t'(b_cdy_reg) - prac_pkg::sum_t'(b_sdx_reg)
                        + prac_pkg::ROUND_Q30;
            c_cx_reg <= b_cx_reg;
            c_cy_reg <= b_cy_reg;
        end
        if (d_rdy && c_valid_reg)
            d_data_reg <= d_data_next;
    end

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && d_data_reg.saturated) |->
            (d_data_reg.rotated_x == prac_pkg::COORD_MAX ||
             d_data_reg.rotated_x == prac_pkg::COORD_MIN ||
             d_data_reg.rotated_y == prac_pkg::COORD_MAX ||
             d_data_reg.rotated_y == prac_pkg::COORD_MIN))
        else $error("saturation flag without clamped coordinate");

endmodule
`default_nettype wire

### rtl/core/point_rotate_about_center_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotate_about_center_unit: rotate a point about a pivot
// Top level: angle reduction, CORDIC cell chain, product and clamp stages.
// ----------------------------------------------------------------------------
// Accepts one item per clock and returns one result per item, in order.
// Stages: one reduction stage, one cell per CORDIC step, then sign, multiply,
// sum and clamp stages. Every stage has its own valid bit and takes a new item
// whenever the stage after it is empty or moving, so bubbles close up and input
// is still taken while a finished result waits at the output; the input stalls
// only when every stage holds an item.
module point_rotate_about_center_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    prac_in_if.sink    points,
    prac_out_if.source results
);

    localparam int N = prac_pkg::CORDIC_STEPS;

    prac_pkg::point_t  in_data;
    prac_pkg::result_t out_data;
    prac_pkg::cordic_t link_data  [N+1];
    logic              link_valid [N+1];
    logic              link_ready [N+1];

    always_comb
    begin
        in_data.point_x = points.point_x;
        in_data.point_y = points.point_y;
        in_data.pivot_x = points.pivot_x;
        in_data.pivot_y = points.pivot_y;
        in_data.angle   = points.angle;
    end

    prac_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (points.valid),
        .up_ready   (points.ready),
        .up_data    (in_data),
        .down_valid (link_valid[0]),
        .down_ready (link_ready[0]),
        .down_data  (link_data[0])
    );

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        prac_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (prac_pkg::STEP_W'(k)),
            .up_valid   (link_valid[k]),
            .up_ready   (link_ready[k]),
            .up_data    (link_data[k]),
            .down_valid (link_valid[k+1]),
            .down_ready (link_ready[k+1]),
            .down_data  (link_data[k+1])
        );
    end

    prac_combine u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (link_valid[N]),
        .up_ready   (link_ready[N]),
        .up_data    (link_data[N]),
        .down_valid (results.valid),
        .down_ready (results.ready),
        .down_data  (out_data)
    );

    assign results.rotated_x = out_data.rotated_x;
    assign results.rotated_y = out_data.rotated_y;
    assign results.saturated = out_data.saturated;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> (results.valid && !results.ready))
        else $error("input stalled while output can drain");

    a_full_chain_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> (link_valid[0] && link_valid[N]))
        else $error("input stalled with empty stage in chain");

endmodule
`default_nettype wire

### tb/sv/point_rotation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_rotation_checker: predicts and checks rotated points
// Watches the point and result channels. Each accepted point is run through a
// CORDIC rotation predictor and queued. Each accepted result is compared field
// by field with the oldest queued rotation. Failures and pending items are
// reported to the top.
// ----------------------------------------------------------------------------
module point_rotation_checker (
    input  logic clk,
    input  logic rst_n,
    prac_in_if   points,
    prac_out_if  results,
    output int   fail_count,
    output int   pending,
    output int   clipped_count
);
    import prac_pkg::*;

    localparam longint HALF_LSB_Q30 = longint'(1) << 29;

    result_t expected_rotations [$];
    int      errors  = 0;
    int      clipped = 0;

    function automatic result_t rotate_point(point_t p);
        longint  x;
        longint  y;
        longint  z;
        longint  xs;
        longint  ys;
        longint  dx;
        longint  dy;
        longint  rx;
        longint  ry;
        bit      flip;
        int      steps;
        result_t r;

        x     = longint'(GAIN_Q30);
        y     = 0;
        z     = longint'($signed(p.angle)) * 16;
        flip  = 1'b0;
        steps = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

        if (z > longint'(ANG_PI))
            z = z - longint'(ANG_TWO_PI);
        if (z < -longint'(ANG_PI))
            z = z + longint'(ANG_TWO_PI);
        if (z > longint'(ANG_HALF_PI))
        begin
            z    = z - longint'(ANG_PI);
            flip = 1'b1;
        end
        else if (z < -longint'(ANG_HALF_PI))
        begin
            z    = z + longint'(ANG_PI);
            flip = 1'b1;
        end

        for (int i = 0; i < steps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_Q16[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_Q16[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end

        // x is cos, y is sin, both Q.30
        dx = longint'($signed(p.point_x)) - longint'($signed(p.pivot_x));
        dy = longint'($signed(p.point_y)) - longint'($signed(p.pivot_y));
        rx = ((x * dx + y * dy + HALF_LSB_Q30) >>> 30) + longint'($signed(p.pivot_x));
        ry = ((-y * dx + x * dy + HALF_LSB_Q30) >>> 30) + longint'($signed(p.pivot_y));

        r.saturated = 1'b0;
        if (rx > longint'(COORD_MAX))
        begin
            rx          = longint'(COORD_MAX);
            r.saturated = 1'b1;
        end
        else if (rx < longint'(COORD_MIN))
        begin
            rx          = longint'(COORD_MIN);
            r.saturated = 1'b1;
        end
        if (ry > longint'(COORD_MAX))
        begin
            ry          = longint'(COORD_MAX);
            r.saturated = 1'b1;
        end
        else if (ry < longint'(COORD_MIN))
        begin
            ry          = longint'(COORD_MIN);
            r.saturated = 1'b1;
        end
        r.rotated_x = coord_t'(rx);
        r.rotated_y = coord_t'(ry);
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                if (results.saturated === 1'b1)
                    clipped++;
                if (expected_rotations.size() == 0)
                begin
                    $error("unexpected result item: rotated_x %0d rotated_y %0d",
                           results.rotated_x, results.rotated_y);
                    errors++;
                end
                else
                begin
                    want = expected_rotations.pop_front();
                    if (results.rotated_x !== want.rotated_x)
                    begin
                        $error("rotated_x: expected %0d, actual %0d",
                               want.rotated_x, results.rotated_x);
                        errors++;
                    end
                    if (results.rotated_y !== want.rotated_y)
                    begin
                        $error("rotated_y: expected %0d, actual %0d",
                               want.rotated_y, results.rotated_y);
                        errors++;
                    end
                    if (results.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, results.saturated);
                        errors++;
                    end
                end
            end
            if (points.valid && points.ready)
                expected_rotations.push_back(rotate_point(point_t'{
                    points.point_x, points.point_y,
                    points.pivot_x, points.pivot_y, points.angle}));
        end
        fail_count    <= errors;
        pending       <= expected_rotations.size();
        clipped_count <= clipped;
    end

endmodule

### tb/sv/tb_point_rotate_about_center_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_rotate_about_center_unit: testbench top for point rotation
// Drives directed points (angle wrap and fold edges, coordinate extremes,
// clipping) and then random points with idle bursts on both channels. The
// checker predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_point_rotate_about_center_unit;
    import prac_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_ITEMS  = 250;
    localparam int TAIL_CYCLES  = CORDIC_STEPS + 30;
    localparam int CYCLE_LIMIT  = 300000;

    localparam coord_t EDGE_COORDS [5] = '{COORD_MAX, COORD_MIN, 32'sd0, -32'sd1, 32'sd1};
    localparam angle_t EDGE_ANGLES [10] = '{
        16'sd6434, 16'sd6435, -16'sd6434, -16'sd6435,
        16'sd12867, 16'sd12868, -16'sd12867, -16'sd12868,
        16'sd25736, -16'sd25736
    };

    logic clk = 1'b0;
    logic rst_n;
    bit   gaps_on  = 1'b0;
    bit   stall_on = 1'b0;
    int   items_sent = 0;
    int   fail_count;
    int   pending;
    int   clipped_count;
    int   cycles = 0;
    int   n;

    prac_in_if  points ();
    prac_out_if results ();

    point_rotate_about_center_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .results (results)
    );

    point_rotation_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .points        (points),
        .results       (results),
        .fail_count    (fail_count),
        .pending       (pending),
        .clipped_count (clipped_count)
    );

    always #5 clk = ~clk;

    task automatic send_item(input point_t p);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            points.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        points.valid   <= 1'b1;
        points.point_x <= p.point_x;
        points.point_y <= p.point_y;
        points.pivot_x <= p.pivot_x;
        points.pivot_y <= p.pivot_y;
        points.angle   <= p.angle;
        @(posedge clk);
        while (!points.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        points.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic point_t random_point();
        point_t p;
        coord_t ofs_x;
        coord_t ofs_y;
        int     mode;

        mode      = $urandom_range(0, 9);
        p.pivot_x = $urandom;
        p.pivot_y = $urandom;
        p.point_x = $urandom;
        p.point_y = $urandom;
        p.angle   = angle_t'($urandom);
        if (mode < 6)
        begin
            // point near the pivot, offsets of varied magnitude
            ofs_x     = $urandom;
            ofs_y     = $urandom;
            ofs_x     = ofs_x >>> $urandom_range(2, 28);
            ofs_y     = ofs_y >>> $urandom_range(2, 28);
            p.point_x = p.pivot_x + ofs_x;
            p.point_y = p.pivot_y + ofs_y;
        end
        else if (mode == 8)
        begin
            p.point_x = EDGE_COORDS[$urandom_range(0, 4)];
            p.point_y = EDGE_COORDS[$urandom_range(0, 4)];
            p.pivot_x = EDGE_COORDS[$urandom_range(0, 4)];
            p.pivot_y = EDGE_COORDS[$urandom_range(0, 4)];
        end
        else if (mode == 9)
            p.angle = EDGE_ANGLES[$urandom_range(0, 9)] + angle_t'($urandom_range(0, 2)) - 16'sd1;
        return p;
    endfunction

    // result side: random stall bursts
    initial
    begin
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 4) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            results.ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("point_rotate_about_center_unit: mismatch");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        points.valid   <= 1'b0;
        points.point_x <= '0;
        points.point_y <= '0;
        points.pivot_x <= '0;
        points.pivot_y <= '0;
        points.angle   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_item(point_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0});
        send_item(point_t'{32'sh10000, 32'sd0, 32'sd0, 32'sd0, 16'sd6434});
        foreach (EDGE_ANGLES[i])
            send_item(point_t'{32'sh10000, 32'sh20000, -32'sh30000, 32'sh50000, EDGE_ANGLES[i]});
        send_item(point_t'{32'sh10000, 32'sh20000, -32'sh30000, 32'sh50000, 16'sh7fff});
        send_item(point_t'{32'sh10000, 32'sh20000, -32'sh30000, 32'sh50000, -16'sh8000});
        // clipping: far corner turned by pi
        send_item(point_t'{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'sd12868});
        send_item(point_t'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'sd0});
        send_item(point_t'{COORD_MAX, COORD_MIN, 32'sd0, 32'sd0, 16'sd6434});
        send_item(point_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'sh7fff});
        send_item(point_t'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, -16'sh8000});
        send_item(point_t'{COORD_MAX, COORD_MAX, 32'sd0, 32'sd0, 16'sd3217});
        send_item(point_t'{-32'sd1, 32'sd1, 32'sd1, -32'sd1, 16'sd1});
        send_item(point_t'{32'sh12345678, -32'sh1234567, 32'sh12345678, -32'sh1234567,
                           -16'sd1});
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                gaps_on  = ($urandom_range(0, 2) != 0);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
            begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            send_item(random_point());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d points: angle wrap and fold edges, coordinate extremes, random",
                 items_sent);
        $display("offsets and pivots under idle bursts; %0d results were clipped",
                 clipped_count);
        if (fail_count == 0 && pending == 0)
            $display("point_rotate_about_center_unit: match");
        else
            $display("point_rotate_about_center_unit: mismatch");
        $finish;
    end

endmodule
